// ===== design/ofb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared constants, request codes and control types of the page framebuffer.
// ----------------------------------------------------------------------------
package ofb_pkg;

  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int ROWS       = 8 * PAGES;
  localparam int STORE_SIZE = COLUMNS * PAGES;
  localparam int GROUP_LEN  = COLUMNS + 3;
  localparam int ADDR_W     = $clog2(STORE_SIZE);
  localparam int PAGE_W     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int BYTE_W     = $clog2(GROUP_LEN);

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LO    = 8'h00;
  localparam logic [7:0] CMD_COL_HI    = 8'h10;

  typedef enum logic [1:0] {
    REQ_DRAW  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_START = 2'd2,
    REQ_TICK  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DRAW_WR,
    ST_TICK_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic draw_wr;
    logic clr_wr;
    logic start;
    logic emit;
  } ofb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw_ok;
    logic active;
    logic clr_last;
    logic out_free;
  } ofb_sts_t;

endpackage
`default_nettype wire

// ===== design/ofb_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_ctrl
// Request sequencer: store clearing sweep, draw read-modify-write, refresh tick.
// ----------------------------------------------------------------------------
module ofb_ctrl
  import ofb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     req_valid_i,
  input  wire req_e     req_type_i,
  input  wire ofb_sts_t sts_i,
  output logic          req_ready_o,
  output ofb_cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o  = 1'b1;
        cmd_o.accept = req_valid_i;
        if (req_valid_i) begin
          case (req_type_i)
            REQ_DRAW: begin
              if (sts_i.draw_ok) begin
                state_d = ST_DRAW_WR;
              end
            end
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_START: cmd_o.start = 1'b1;
            REQ_TICK: begin
              // drop the tick when no refresh runs
              if (sts_i.active) begin
                state_d = ST_TICK_OUT;
              end
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_DRAW_WR: begin
        cmd_o.draw_wr = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_TICK_OUT: begin
        // hold until the output register can take the byte
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/ofb_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ofb_datapath
// Frame store memory, refresh counters and the output register.
// ----------------------------------------------------------------------------
module ofb_datapath
  import ofb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire ofb_cmd_t   cmd_i,
  input  wire req_e       req_type_i,
  input  wire logic [7:0] column_i,
  input  wire logic [7:0] row_i,
  input  wire logic       pixel_on_i,
  input  wire logic       out_ready_i,
  output ofb_sts_t        sts_o,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            is_data_o,
  output logic            frame_done_o
);

  logic [7:0] mem [STORE_SIZE];

  logic [ADDR_W-1:0] clr_q;
  logic              active_q;
  logic [PAGE_W-1:0] page_q;
  logic [BYTE_W-1:0] byte_q;
  logic              out_valid_q;

  logic [ADDR_W-1:0] addr_q;
  logic [7:0]        mask_q;
  logic              pix_q;
  logic [7:0]        rd_q;
  logic [7:0]        out_byte_q;
  logic              is_data_q;
  logic              frame_done_q;

  logic              draw_ok;
  logic [PAGE_W-1:0] draw_page;
  logic [ADDR_W-1:0] draw_addr;
  logic [ADDR_W-1:0] tick_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        mask;
  logic [7:0]        cmd_byte;
  logic              page_end;
  logic              last_page;

  assign draw_ok   = ({1'b0, column_i} < 9'(COLUMNS)) && ({1'b0, row_i} < 9'(ROWS));
  assign draw_page = PAGE_W'(PAGES - 1) - PAGE_W'(row_i >> 3);
  assign draw_addr = ADDR_W'(int'(draw_page) * COLUMNS) + ADDR_W'(column_i);
  assign tick_addr = ADDR_W'(int'(page_q) * COLUMNS) + ADDR_W'(byte_q - BYTE_W'(3));
  assign rd_addr   = (req_type_i == REQ_DRAW) ? draw_addr : tick_addr;
  assign mask      = 8'h80 >> row_i[2:0];

  assign page_end  = (byte_q == BYTE_W'(GROUP_LEN - 1));
  assign last_page = (page_q == PAGE_W'(PAGES - 1));

  always_comb begin
    case (byte_q)
      BYTE_W'(0): cmd_byte = CMD_PAGE_BASE + 8'(page_q);
      BYTE_W'(1): cmd_byte = CMD_COL_LO;
      BYTE_W'(2): cmd_byte = CMD_COL_HI;
      default:    cmd_byte = rd_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_wr) begin
      mem[clr_q] <= 8'h00;
    end else if (cmd_i.draw_wr) begin
      mem[addr_q] <= pix_q ? (rd_q | mask_q) : (rd_q & ~mask_q);
    end
    if (cmd_i.accept) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q <= draw_addr;
      mask_q <= mask;
      pix_q  <= pixel_on_i;
    end
    if (cmd_i.emit) begin
      out_byte_q   <= cmd_byte;
      is_data_q    <= (byte_q > BYTE_W'(2));
      frame_done_q <= last_page && page_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      active_q    <= 1'b0;
      page_q      <= '0;
      byte_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= sts_o.clr_last ? '0 : clr_q + ADDR_W'(1);
      end
      if (cmd_i.start) begin
        active_q <= 1'b1;
        page_q   <= '0;
        byte_q   <= '0;
      end else if (cmd_i.emit) begin
        if (page_end) begin
          byte_q <= '0;
          if (last_page) begin
            page_q   <= '0;
            active_q <= 1'b0;
          end else begin
            page_q <= page_q + PAGE_W'(1);
          end
        end else begin
          byte_q <= byte_q + BYTE_W'(1);
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.draw_ok  = draw_ok;
  assign sts_o.active   = active_q;
  assign sts_o.clr_last = (clr_q == ADDR_W'(STORE_SIZE - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_data_o    = is_data_q;
  assign frame_done_o = frame_done_q;

endmodule
`default_nettype wire

// ===== design/oled_page_framebuffer_refresh.sv =====
// Draw: request taken and memory read in ST_IDLE, memory written the next cycle in
//   ST_DRAW_WR; no new request is taken until the write is done.
// Tick: registered memory read in ST_IDLE, byte loaded in ST_TICK_OUT once the output
//   register is free. Clear: one entry per cycle over all 1024 store entries.
// Reset: asynchronous; afterwards the same clearing sweep over the store runs with
//   s_axis_tready low.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oled_page_framebuffer_refresh
// Page framebuffer for a monochrome OLED with page-mode refresh byte stream.
// ----------------------------------------------------------------------------
module oled_page_framebuffer_refresh
  import ofb_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // column[7:0], row[15:8], pixel_on[16], zero
  input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte[7:0]
  output logic             m_axis_tuser,  // is_data[0]
  output logic             m_axis_tlast   // frame_done
);

  ofb_cmd_t cmd;
  ofb_sts_t sts;
  req_e     req_type;

  assign req_type = req_e'(s_axis_tuser);

  ofb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_type_i  (req_type),
    .sts_i       (sts),
    .req_ready_o (s_axis_tready),
    .cmd_o       (cmd)
  );

  ofb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type),
    .column_i     (s_axis_tdata[7:0]),
    .row_i        (s_axis_tdata[15:8]),
    .pixel_on_i   (s_axis_tdata[16]),
    .out_ready_i  (m_axis_tready),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (m_axis_tdata),
    .is_data_o    (m_axis_tuser),
    .frame_done_o (m_axis_tlast)
  );

endmodule
`default_nettype wire
